>>> hw/rtl/quadrature_jog_to_relative_cc_macros.svh
// assertion helpers shared by the block
`ifndef QUADRATURE_JOG_TO_RELATIVE_CC_MACROS_SVH
`define QUADRATURE_JOG_TO_RELATIVE_CC_MACROS_SVH

// property holds in every cycle out of reset
`define QJRC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define QJRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/qjrc_pkg.sv
`timescale 1ns / 1ps
package qjrc_pkg;

  // control-change framing
  localparam logic [7:0] CC_STATUS   = 8'hB0;
  localparam logic [3:0] CHAN_MASK   = 4'hF;
  localparam int         DRAIN_LIMIT = 63;
  localparam logic [6:0] REL_CENTER  = 7'd64;

  // register reset values
  localparam logic [3:0] CC_CHAN_RST = 4'd0;
  localparam logic [6:0] CTRL_A_RST  = 7'd16;
  localparam logic [6:0] CTRL_B_RST  = 7'd17;

  // register indexes
  localparam logic [1:0] REG_CC_CHAN     = 2'd0;
  localparam logic [1:0] REG_CTRL_DECK_A = 2'd1;
  localparam logic [1:0] REG_CTRL_DECK_B = 2'd2;

  // request codes
  localparam logic REQ_POLL = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // result queue geometry
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  // x4 gray-code step, indexed by {prev, cur}
  localparam logic signed [1:0] GRAY_STEP [16] = '{
    2'sd0,  2'sd1,  -2'sd1, 2'sd0,
    -2'sd1, 2'sd0,  2'sd0,  2'sd1,
    2'sd1,  2'sd0,  2'sd0,  -2'sd1,
    2'sd0,  -2'sd1, 2'sd1,  2'sd0
  };

  typedef struct packed {
    logic [3:0] cc_chan;
    logic [6:0] ctrl_deck_a;
    logic [6:0] ctrl_deck_b;
  } cfg_t;

  typedef struct packed {
    logic       send;
    logic [6:0] rel_value;
  } deck_report_t;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [6:0] controller;
    logic [6:0] rel_value;
    logic       last_of_tick;
  } result_t;

  typedef struct packed {
    logic [1:0] num;
    result_t    first;
    result_t    second;
  } push_t;

  typedef struct packed {
    logic [FIFO_CW-1:0] fill;
  } fifo_stat_t;

endpackage

>>> hw/rtl/qjrc_in_if.sv
`timescale 1ns / 1ps
interface qjrc_in_if;
  logic valid;
  logic ready;
  logic req_type;
  logic deck_a_phase_a;
  logic deck_a_phase_b;
  logic deck_b_phase_a;
  logic deck_b_phase_b;

  modport source (
    output valid, req_type, deck_a_phase_a, deck_a_phase_b, deck_b_phase_a, deck_b_phase_b,
    input  ready
  );
  modport sink (
    input  valid, req_type, deck_a_phase_a, deck_a_phase_b, deck_b_phase_a, deck_b_phase_b,
    output ready
  );
endinterface

>>> hw/rtl/qjrc_out_if.sv
`timescale 1ns / 1ps
interface qjrc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] status_byte;
  logic [6:0] controller;
  logic [6:0] rel_value;
  logic       last_of_tick;

  modport source (
    output valid, status_byte, controller, rel_value, last_of_tick,
    input  ready
  );
  modport sink (
    input  valid, status_byte, controller, rel_value, last_of_tick,
    output ready
  );
endinterface

>>> hw/rtl/qjrc_cfg.sv
`timescale 1ns / 1ps
module qjrc_cfg import qjrc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = paddr[3:2];

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cc_chan     <= CC_CHAN_RST;
      cfg_q.ctrl_deck_a <= CTRL_A_RST;
      cfg_q.ctrl_deck_b <= CTRL_B_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_CC_CHAN:     cfg_q.cc_chan     <= pwdata[3:0];
        REG_CTRL_DECK_A: cfg_q.ctrl_deck_a <= pwdata[6:0];
        REG_CTRL_DECK_B: cfg_q.ctrl_deck_b <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (idx)
      REG_CC_CHAN:     prdata = {28'd0, cfg_q.cc_chan};
      REG_CTRL_DECK_A: prdata = {25'd0, cfg_q.ctrl_deck_a};
      REG_CTRL_DECK_B: prdata = {25'd0, cfg_q.ctrl_deck_b};
      default:         prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> hw/rtl/qjrc_deck.sv
`timescale 1ns / 1ps
module qjrc_deck import qjrc_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         poll_i,
  input  logic         seeded_i,
  input  logic         tick_i,
  input  logic [1:0]   cur_i,
  output deck_report_t report_o
);

  localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
  localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
  localparam logic signed [COUNT_WIDTH-1:0] LIM_POS = COUNT_WIDTH'(DRAIN_LIMIT);
  localparam logic signed [COUNT_WIDTH-1:0] LIM_NEG = -LIM_POS;

  logic [1:0]                    prev_q, prev_d;
  logic signed [COUNT_WIDTH-1:0] count_q, count_d;
  logic signed [1:0]             step;
  logic signed [6:0]             delta;

  assign step = GRAY_STEP[{prev_q, cur_i}];

  // clamp the pending count to what one message can carry
  always_comb begin
    priority if (count_q > LIM_POS) delta = 7'(DRAIN_LIMIT);
    else if (count_q < LIM_NEG)     delta = -7'(DRAIN_LIMIT);
    else                            delta = count_q[6:0];
  end

  // counter: drain on tick, saturating step on a seeded poll; every poll records the phase
  always_comb begin
    count_d = count_q;
    prev_d  = prev_q;
    if (tick_i) begin
      count_d = count_q - {{(COUNT_WIDTH-7){delta[6]}}, delta};
    end else if (poll_i) begin
      prev_d = cur_i;
      if (seeded_i) begin
        if ((step == 2'sd1 && count_q == CNT_MAX) || (step == -2'sd1 && count_q == CNT_MIN)) begin
          count_d = count_q;
        end else begin
          count_d = count_q + {{(COUNT_WIDTH-2){step[1]}}, step};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= 2'd0;
      count_q <= '0;
    end else begin
      prev_q  <= prev_d;
      count_q <= count_d;
    end
  end

  assign report_o.send      = (count_q != '0);
  assign report_o.rel_value = REL_CENTER + delta;

endmodule

>>> hw/rtl/qjrc_res_fifo.sv
`timescale 1ns / 1ps
module qjrc_res_fifo import qjrc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  push_t      push_i,
  input  logic       pop_i,
  output result_t    head_o,
  output fifo_stat_t stat_o
);

  result_t            mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, rd_q;
  logic [FIFO_CW-1:0] fill_q;
  logic [FIFO_AW-1:0] wr_next;

  assign wr_next = FIFO_AW'(wr_q + 1'b1);

  // entry storage, up to two items written per cycle
  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) mem_q[wr_q] <= push_i.first;
    if (push_i.num == 2'd2) mem_q[wr_next] <= push_i.second;
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= FIFO_AW'(wr_q + FIFO_AW'(push_i.num));
      if (pop_i) rd_q <= FIFO_AW'(rd_q + 1'b1);
      fill_q <= FIFO_CW'(fill_q + FIFO_CW'(push_i.num) - FIFO_CW'(pop_i));
    end
  end

  assign head_o      = mem_q[rd_q];
  assign stat_o.fill = fill_q;

endmodule

>>> hw/rtl/quadrature_jog_to_relative_cc.sv
`timescale 1ns / 1ps
// timing: a poll item updates the deck counters at its acceptance edge; a tick item's
// results leave the queue no earlier than the cycle after acceptance, one per cycle
// while res_o.ready is high; throughput: one poll item per cycle while the 4-entry
// queue has two free slots, which ticks need; two-item ticks are paced by the output.
// reset: rst_ni is asynchronous, active low; clears counters, phase history, seed flag,
// result queue, and loads the register reset values
module quadrature_jog_to_relative_cc import qjrc_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  qjrc_in_if.sink     req_i,
  qjrc_out_if.source  res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

`include "quadrature_jog_to_relative_cc_macros.svh"

  cfg_t         cfg;
  deck_report_t rep_a, rep_b;
  push_t        push;
  result_t      head;
  fifo_stat_t   fstat;
  logic         accept, poll, tick, pop;
  logic         tick_send;
  logic         seeded_q;
  result_t      res_a, res_b;
  logic [7:0]   status;

  qjrc_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o (cfg)
  );

  // input handshake, a tick needs room for two items
  assign req_i.ready = (fstat.fill <= FIFO_CW'(FIFO_DEPTH - 2));
  assign accept      = req_i.valid & req_i.ready;
  assign poll        = accept & (req_i.req_type == REQ_POLL);
  assign tick        = accept & (req_i.req_type == REQ_TICK);

  // first poll only seeds the phase history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) seeded_q <= 1'b0;
    else if (poll) seeded_q <= 1'b1;
  end

  qjrc_deck #(.COUNT_WIDTH(COUNT_WIDTH)) u_deck_a (
    .clk_i, .rst_ni, .poll_i(poll), .seeded_i(seeded_q), .tick_i(tick),
    .cur_i({req_i.deck_a_phase_a, req_i.deck_a_phase_b}), .report_o(rep_a)
  );

  qjrc_deck #(.COUNT_WIDTH(COUNT_WIDTH)) u_deck_b (
    .clk_i, .rst_ni, .poll_i(poll), .seeded_i(seeded_q), .tick_i(tick),
    .cur_i({req_i.deck_b_phase_a, req_i.deck_b_phase_b}), .report_o(rep_b)
  );

  // build the control-change items, deck a first
  assign status = CC_STATUS | {4'd0, cfg.cc_chan & CHAN_MASK};
  assign res_a  = '{status_byte: status, controller: cfg.ctrl_deck_a,
                    rel_value: rep_a.rel_value, last_of_tick: ~rep_b.send};
  assign res_b  = '{status_byte: status, controller: cfg.ctrl_deck_b,
                    rel_value: rep_b.rel_value, last_of_tick: 1'b1};

  always_comb begin
    push.first  = rep_a.send ? res_a : res_b;
    push.second = res_b;
    push.num    = tick ? (2'(rep_a.send) + 2'(rep_b.send)) : 2'd0;
  end

  assign tick_send = tick & (rep_a.send | rep_b.send);

  assign pop = res_o.valid & res_o.ready;

  qjrc_res_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .pop_i(pop), .head_o(head), .stat_o(fstat)
  );

  assign res_o.valid        = (fstat.fill != '0);
  assign res_o.status_byte  = head.status_byte;
  assign res_o.controller   = head.controller;
  assign res_o.rel_value    = head.rel_value;
  assign res_o.last_of_tick = head.last_of_tick;

  // checks
  `QJRC_ASSERT(a_fill_bound, clk_i, rst_ni, fstat.fill <= FIFO_CW'(FIFO_DEPTH), "queue overfilled")
  `QJRC_ASSERT_NEXT(a_tick_emits, clk_i, rst_ni, tick_send, res_o.valid, "tick gave no item")
  `QJRC_ASSERT_NEXT(a_poll_silent, clk_i, rst_ni, poll, fstat.fill <= $past(fstat.fill), "poll push")

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import qjrc_pkg::*;

  localparam int CNT_W       = 16;
  localparam int CNT_MAX     = 2 ** (CNT_W - 1) - 1;
  localparam int CNT_MIN     = -(2 ** (CNT_W - 1));
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 4;
  localparam int HOLD_CYCLES = 300;

  // index past the last register, must be ignored
  localparam logic [1:0] REG_SPARE = 2'd3;

  // per-poll motion of one encoder, in gray positions
  localparam logic [1:0] STEP_NONE = 2'd0;
  localparam logic [1:0] STEP_FWD  = 2'd1;
  localparam logic [1:0] STEP_REV  = 2'd3;

  typedef struct packed {
    logic       req_type;
    logic [1:0] pins_a;   // {phase_a, phase_b} of deck A
    logic [1:0] pins_b;   // {phase_a, phase_b} of deck B
  } jog_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  qjrc_in_if  req_if ();
  qjrc_out_if res_if ();

  quadrature_jog_to_relative_cc #(.COUNT_WIDTH(CNT_W)) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predicted block state
  logic [3:0]              cfg_chan;
  logic [6:0]              cfg_ctrl_a;
  logic [6:0]              cfg_ctrl_b;
  logic [1:0]              last_pins_a;
  logic [1:0]              last_pins_b;
  logic signed [CNT_W-1:0] jog_cnt_a;
  logic signed [CNT_W-1:0] jog_cnt_b;
  logic                    pins_seeded;

  jog_item_t jog_items_q[$];
  result_t   cc_expected_q[$];
  jog_item_t drv_item;
  int        drv_gap;
  int        mon_gap;
  int        err_cnt;
  int        cycle_cnt;
  int        items_pushed;
  int        stall_left;
  bit        stall_req;
  bit        idle_on;
  logic [1:0] gen_a;
  logic [1:0] gen_b;

  always #6 clk_i = ~clk_i;

  // 2-bit gray <-> position, the mapping is its own inverse
  function automatic logic [1:0] gray2(logic [1:0] v);
    return {v[1], v[1] ^ v[0]};
  endfunction

  // one x4 decode step, saturating at the counter range
  function automatic logic signed [CNT_W-1:0] jog_step(logic signed [CNT_W-1:0] cnt,
                                                        logic [1:0] prev, logic [1:0] cur);
    logic [1:0] span;
    int         nxt;
    span = gray2(cur) - gray2(prev);
    nxt  = int'(cnt);
    if (span == STEP_FWD) nxt++;
    else if (span == STEP_REV) nxt--;
    if (nxt > CNT_MAX) nxt = CNT_MAX;
    if (nxt < CNT_MIN) nxt = CNT_MIN;
    return CNT_W'(nxt);
  endfunction

  // part of a count that one message can carry
  function automatic int clamp_delta(logic signed [CNT_W-1:0] cnt);
    int v;
    v = int'(cnt);
    if (v > DRAIN_LIMIT) return DRAIN_LIMIT;
    if (v < -DRAIN_LIMIT) return -DRAIN_LIMIT;
    return v;
  endfunction

  // update decoder state and queue the control-change items of one request
  function automatic void predict_jog(jog_item_t it);
    int   da;
    int   db;
    logic send_a;
    logic send_b;
    if (it.req_type == REQ_POLL) begin
      if (pins_seeded) begin
        jog_cnt_a = jog_step(jog_cnt_a, last_pins_a, it.pins_a);
        jog_cnt_b = jog_step(jog_cnt_b, last_pins_b, it.pins_b);
      end
      last_pins_a = it.pins_a;
      last_pins_b = it.pins_b;
      pins_seeded = 1'b1;
    end else begin
      send_a = (jog_cnt_a != 0);
      send_b = (jog_cnt_b != 0);
      if (send_a) begin
        da        = clamp_delta(jog_cnt_a);
        jog_cnt_a = jog_cnt_a - CNT_W'(da);
        cc_expected_q.push_back('{status_byte: CC_STATUS | {4'h0, cfg_chan},
                                  controller: cfg_ctrl_a,
                                  rel_value: REL_CENTER + 7'(da),
                                  last_of_tick: !send_b});
      end
      if (send_b) begin
        db        = clamp_delta(jog_cnt_b);
        jog_cnt_b = jog_cnt_b - CNT_W'(db);
        cc_expected_q.push_back('{status_byte: CC_STATUS | {4'h0, cfg_chan},
                                  controller: cfg_ctrl_b,
                                  rel_value: REL_CENTER + 7'(db),
                                  last_of_tick: 1'b1});
      end
    end
  endfunction

  // mostly back to back, sometimes short gaps, rarely long ones
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [1:0] pick_dir();
    case ($urandom_range(2))
      0: return STEP_FWD;
      1: return STEP_REV;
      default: return STEP_NONE;
    endcase
  endfunction

  task automatic report(string msg);
    $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    err_cnt++;
  endtask

  task automatic push_item(logic req, logic [1:0] a, logic [1:0] b);
    jog_items_q.push_back('{req_type: req, pins_a: a, pins_b: b});
    items_pushed++;
  endtask

  task automatic push_pins(logic [1:0] a, logic [1:0] b);
    push_item(REQ_POLL, a, b);
    gen_a = gray2(a);
    gen_b = gray2(b);
  endtask

  // pins are don't-care on a tick, so randomize them
  task automatic push_tick();
    push_item(REQ_TICK, 2'($urandom), 2'($urandom));
  endtask

  // well-formed rotation of both encoders
  task automatic spin(int n, logic [1:0] da, logic [1:0] db);
    repeat (n) push_pins(gray2(gen_a + da), gray2(gen_b + db));
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [6:0] val);
    logic [31:0] junk;
    junk = $urandom();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {junk[31:7], val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_CC_CHAN:     cfg_chan   = val[3:0];
      REG_CTRL_DECK_A: cfg_ctrl_a = val;
      REG_CTRL_DECK_B: cfg_ctrl_b = val;
      default: ;
    endcase
  endtask

  task automatic cfg_set(logic [3:0] chan, logic [6:0] ctrl_a, logic [6:0] ctrl_b);
    cfg_write(REG_CC_CHAN, {3'($urandom), chan});
    cfg_write(REG_CTRL_DECK_A, ctrl_a);
    cfg_write(REG_CTRL_DECK_B, ctrl_b);
  endtask

  // all items sent, all results back, then a drain wait for a trailing poll
  task automatic wait_idle();
    while (jog_items_q.size() != 0 || req_if.valid || cc_expected_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // rotation bursts closed by a tick, plus stray pins and stray ticks
  task automatic random_block(int n);
    int stop;
    int r;
    int len;
    stop = items_pushed + n;
    while (items_pushed < stop) begin
      idle_on = ($urandom_range(9) != 0);
      r = $urandom_range(99);
      if (r < 70) begin
        len = ($urandom_range(99) < 90) ? $urandom_range(1, 12) : $urandom_range(64, 100);
        spin(len, pick_dir(), pick_dir());
        push_tick();
      end else if (r < 85) begin
        push_pins(2'($urandom), 2'($urandom));
      end else begin
        push_tick();
      end
    end
    idle_on = 1'b1;
  endtask

  // request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) predict_jog(drv_item);
      if (!req_if.valid || req_if.ready) begin
        if (drv_gap > 0) begin
          drv_gap--;
          req_if.valid <= 1'b0;
        end else if (jog_items_q.size() != 0) begin
          drv_item = jog_items_q.pop_front();
          req_if.valid          <= 1'b1;
          req_if.req_type       <= drv_item.req_type;
          req_if.deck_a_phase_a <= drv_item.pins_a[1];
          req_if.deck_a_phase_b <= drv_item.pins_a[0];
          req_if.deck_b_phase_a <= drv_item.pins_b[1];
          req_if.deck_b_phase_b <= drv_item.pins_b[0];
          drv_gap = pick_gap();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off on request
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (stall_req) begin
      stall_left <= HOLD_CYCLES;
      stall_req = 1'b0;
    end
  end

  // result monitor and checker
  always @(posedge clk_i) begin
    result_t exp_cc;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (cc_expected_q.size() == 0) begin
          report($sformatf("unexpected item status %h ctrl %0d value %0d last %0b",
                           res_if.status_byte, res_if.controller, res_if.rel_value,
                           res_if.last_of_tick));
        end else begin
          exp_cc = cc_expected_q.pop_front();
          if (res_if.status_byte !== exp_cc.status_byte)
            report($sformatf("status_byte %h, expected %h",
                             res_if.status_byte, exp_cc.status_byte));
          if (res_if.controller !== exp_cc.controller)
            report($sformatf("controller %0d, expected %0d",
                             res_if.controller, exp_cc.controller));
          if (res_if.rel_value !== exp_cc.rel_value)
            report($sformatf("rel_value %0d, expected %0d",
                             res_if.rel_value, exp_cc.rel_value));
          if (res_if.last_of_tick !== exp_cc.last_of_tick)
            report($sformatf("last_of_tick %0b, expected %0b",
                             res_if.last_of_tick, exp_cc.last_of_tick));
        end
      end
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
      end else if (mon_gap > 0) begin
        mon_gap--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
        mon_gap = pick_gap();
      end
    end
  end

  // run watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("cycle limit reached with %0d results outstanding", cc_expected_q.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_ni                = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    req_if.valid          = 1'b0;
    req_if.req_type       = REQ_POLL;
    req_if.deck_a_phase_a = 1'b0;
    req_if.deck_a_phase_b = 1'b0;
    req_if.deck_b_phase_a = 1'b0;
    req_if.deck_b_phase_b = 1'b0;
    res_if.ready          = 1'b0;
    idle_on               = 1'b1;
    cfg_chan              = CC_CHAN_RST;
    cfg_ctrl_a            = CTRL_A_RST;
    cfg_ctrl_b            = CTRL_B_RST;
    last_pins_a           = '0;
    last_pins_b           = '0;
    jog_cnt_a             = '0;
    jog_cnt_b             = '0;
    pins_seeded           = 1'b0;
    gen_a                 = '0;
    gen_b                 = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: seeding, single steps, invalid jumps, one-deck and empty ticks
    push_tick();
    push_pins(2'b11, 2'b10);
    push_pins(2'b10, 2'b00);
    push_pins(2'b11, 2'b10);
    push_tick();
    push_pins(2'b00, 2'b01);
    push_pins(2'b01, 2'b00);
    push_tick();
    push_pins(2'b11, 2'b00);
    push_tick();
    push_pins(2'b11, 2'b10);
    push_tick();
    push_tick();
    wait_idle();

    // write to an unmapped index, then the top channel and both controller extremes
    cfg_write(REG_SPARE, 7'($urandom));
    cfg_set(4'd15, 7'd127, 7'd0);
    random_block(150);
    wait_idle();

    // receiver holds off while ticks keep coming, result queue fills up
    stall_req = 1'b1;
    repeat (30) begin
      spin(1, STEP_FWD, STEP_REV);
      push_tick();
    end
    wait_idle();

    // run both counters well past the clamp, then drain with carried residue
    cfg_set(4'd0, 7'd0, 7'd127);
    idle_on = 1'b0;
    repeat (8) push_tick();
    spin(150, STEP_FWD, STEP_REV);
    repeat (4) push_tick();
    wait_idle();
    idle_on = 1'b1;

    cfg_set(4'($urandom), 7'($urandom), 7'($urandom));
    random_block(150);
    wait_idle();

    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> quadrature_jog_to_relative_cc.f
+incdir+hw/rtl
hw/rtl/qjrc_pkg.sv
hw/rtl/qjrc_in_if.sv
hw/rtl/qjrc_out_if.sv
hw/rtl/qjrc_cfg.sv
hw/rtl/qjrc_deck.sv
hw/rtl/qjrc_res_fifo.sv
hw/rtl/quadrature_jog_to_relative_cc.sv
tb/tb_top.sv
